/* design/sxd_pkg.sv */
package sxd_pkg;

   localparam int CHANNELS = 112;
   localparam int CHAN_W   = 7;

   localparam logic [1:0] CMD_EDGE  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   typedef struct packed {
      logic [1:0]        command;
      logic              data_bit;
      logic [CHAN_W-1:0] channel;
      logic [7:0]        write_data;
      logic [7:0]        write_mask;
   } sxd_req_type;

   typedef struct packed {
      logic              drive_enable;
      logic              drive_value;
      logic [7:0]        read_data;
      logic              write_busy;
      logic              request_accepted;
      logic              track_power;
      logic              byte_stored;
      logic [CHAN_W-1:0] stored_channel;
      logic [7:0]        stored_value;
   } sxd_rsp_type;

   typedef struct packed {
      logic              en;
      logic [CHAN_W-1:0] addr;
      logic [7:0]        data;
   } sxd_wr_type;

endpackage

/* design/selectrix_bus_decoder.sv */
// Selectrix bus decoder with posted masked write.
// Request channel (req_valid / req_stall / req_data): each beat is a bus clock
// edge sample carrying the data line level, a write request (channel, byte,
// bit mask) or a channel read. Response channel (rsp_valid / rsp_stall /
// rsp_data): exactly one beat per request beat, in order, with the line drive
// for the current bit time, read data, write status, track power and any
// channel byte completed on that edge.
// The input register holds a taken request and the response register its
// response. Throughput: one beat per cycle while rsp_stall lets beats move; the
// decoder state, the 112-entry channel store (one write port, one registered
// read port) and the response register all update together when a beat fires.
// Reset clears the sync search, the pending write and the per-channel valid
// bits, so all channels read as zero until the bus fills them; no clearing
// pass is needed and requests are taken at once.
// While rsp_stall holds a full response register, one more request is held in
// the input register and req_stall rises until the response beat moves.
module selectrix_bus_decoder
   import sxd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  sxd_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output sxd_rsp_type rsp_data
);

   logic        s1_valid_ff;
   sxd_req_type s1_ff;
   logic        rsp_valid_ff;
   sxd_rsp_type rsp_ff;
   sxd_rsp_type rsp_next;
   sxd_wr_type  store_wr;
   logic        advance;
   logic        fire;
   logic [7:0]  rd_data;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;

   sxd_bus_fsm u_fsm (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .item     (s1_ff),
      .rsp_next (rsp_next),
      .store_wr (store_wr)
   );

   sxd_chan_mem u_mem (
      .clock    (clock),
      .reset    (reset),
      .store_wr (store_wr),
      .rd_en    (fire),
      .rd_req   (s1_ff.command == CMD_READ),
      .rd_addr  (s1_ff.channel),
      .rd_data  (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            s1_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   // payload registers; hold while stalled
   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         s1_ff <= req_data;
      end
      if (fire) begin
         rsp_ff <= rsp_next;
      end
   end

   always_comb begin
      rsp_data           = rsp_ff;
      rsp_data.read_data = rd_data;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* design/sxd_bus_fsm.sv */
module sxd_bus_fsm
   import sxd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        fire,
   input  sxd_req_type item,
   output sxd_rsp_type rsp_next,
   output sxd_wr_type  store_wr
);

   typedef enum logic [1:0] {
      PH_SYNC = 2'd0,
      PH_ADDR = 2'd1,
      PH_DATA = 2'd2
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [2:0]        zero_count_ff, zero_count_in;
   logic [2:0]        addr_cnt_ff, addr_cnt_in;
   logic [3:0]        base_ff, base_in;
   logic [2:0]        frame_ff, frame_in;
   logic [3:0]        fbit_ff, fbit_in;
   logic [7:0]        shift_ff, shift_in;
   logic              pend_ff, pend_in;
   logic              writing_ff, writing_in;
   logic [CHAN_W-1:0] pend_chan_ff, pend_chan_in;
   logic [7:0]        pend_val_ff, pend_val_in;
   logic [7:0]        pend_mask_ff, pend_mask_in;
   logic              power_ff, power_in;

   always_comb begin
      logic [CHAN_W-1:0] chan;
      logic [2:0]        bit_n;
      logic              data_slot;
      logic              wr;
      logic [2:0]        frame_nx;

      phase_in      = phase_ff;
      zero_count_in = zero_count_ff;
      addr_cnt_in   = addr_cnt_ff;
      base_in       = base_ff;
      frame_in      = frame_ff;
      fbit_in       = fbit_ff;
      shift_in      = shift_ff;
      pend_in       = pend_ff;
      writing_in    = writing_ff;
      pend_chan_in  = pend_chan_ff;
      pend_val_in   = pend_val_ff;
      pend_mask_in  = pend_mask_ff;
      power_in      = power_ff;

      rsp_next = '0;
      store_wr = '0;

      // low nibble is 15-base, upper bits 6-frame; the sum never carries
      chan     = {3'(3'd6 - frame_ff), ~base_ff};
      frame_nx = frame_ff + 3'd1;
      wr       = writing_ff;

      bit_n     = 3'd0;
      data_slot = 1'b1;
      unique case (fbit_ff)
         4'd1:    bit_n = 3'd1;
         4'd3:    bit_n = 3'd2;
         4'd4:    bit_n = 3'd3;
         4'd6:    bit_n = 3'd4;
         4'd7:    bit_n = 3'd5;
         4'd9:    bit_n = 3'd6;
         4'd10:   bit_n = 3'd7;
         default: data_slot = 1'b0;
      endcase

      if (fire) begin
         unique case (item.command)
            CMD_EDGE: begin
               unique case (phase_ff)
                  PH_ADDR: begin
                     unique case (addr_cnt_ff)
                        3'd0: power_in   = item.data_bit;
                        3'd2: base_in[3] = item.data_bit;
                        3'd3: base_in[2] = item.data_bit;
                        3'd5: base_in[1] = item.data_bit;
                        3'd6: base_in[0] = item.data_bit;
                        3'd7: begin
                           phase_in = PH_DATA;
                           frame_in = 3'd0;
                           fbit_in  = 4'd0;
                           shift_in = 8'd0;
                        end
                        default: ;
                     endcase
                     addr_cnt_in = addr_cnt_ff + 3'd1;
                  end
                  PH_DATA: begin
                     unique case (fbit_ff)
                        4'd2, 4'd5, 4'd8: fbit_in = fbit_ff + 4'd1;
                        4'd0: begin
                           // open the write window when the pending channel passes
                           wr         = pend_ff && (chan == pend_chan_ff);
                           writing_in = wr;
                           if (wr && pend_mask_ff[0]) begin
                              rsp_next.drive_enable = 1'b1;
                              rsp_next.drive_value  = pend_val_ff[0];
                           end
                           shift_in = {7'd0, item.data_bit};
                           fbit_in  = fbit_ff + 4'd1;
                        end
                        4'd11: begin
                           if (!item.data_bit) begin
                              // lost framing: drop any write and hunt for sync
                              phase_in      = PH_SYNC;
                              zero_count_in = 3'd0;
                              frame_in      = 3'd0;
                              fbit_in       = 4'd0;
                              writing_in    = 1'b0;
                              pend_in       = 1'b0;
                           end else begin
                              if (writing_ff) begin
                                 writing_in = 1'b0;
                                 pend_in    = 1'b0;
                              end
                              if (chan < CHAN_W'(CHANNELS)) begin
                                 rsp_next.byte_stored    = 1'b1;
                                 rsp_next.stored_channel = chan;
                                 rsp_next.stored_value   = shift_ff;
                                 store_wr.en             = 1'b1;
                                 store_wr.addr           = chan;
                                 store_wr.data           = shift_ff;
                              end
                              frame_in = frame_nx;
                              if (frame_nx == 3'd7) begin
                                 phase_in      = PH_SYNC;
                                 zero_count_in = 3'd0;
                                 frame_in      = 3'd0;
                                 fbit_in       = 4'd0;
                              end else begin
                                 fbit_in  = 4'd0;
                                 shift_in = 8'd0;
                              end
                           end
                        end
                        default: begin
                           if (data_slot) begin
                              if (wr && pend_mask_ff[bit_n]) begin
                                 rsp_next.drive_enable = 1'b1;
                                 rsp_next.drive_value  = pend_val_ff[bit_n];
                              end
                              shift_in = shift_ff | (8'(item.data_bit) << bit_n);
                              fbit_in  = fbit_ff + 4'd1;
                           end else begin
                              fbit_in = 4'd0;
                           end
                        end
                     endcase
                  end
                  default: begin
                     if (!item.data_bit) begin
                        if (zero_count_ff < 3'd4) begin
                           zero_count_in = zero_count_ff + 3'd1;
                        end
                     end else if (zero_count_ff == 3'd3) begin
                        phase_in    = PH_ADDR;
                        base_in     = 4'd0;
                        addr_cnt_in = 3'd0;
                     end else begin
                        zero_count_in = 3'd0;
                     end
                  end
               endcase
            end
            CMD_WRITE: begin
               if (!pend_ff) begin
                  pend_in                   = 1'b1;
                  pend_chan_in              = item.channel;
                  pend_val_in               = item.write_data;
                  pend_mask_in              = item.write_mask;
                  rsp_next.request_accepted = 1'b1;
               end
            end
            default: ;
         endcase
      end

      rsp_next.write_busy  = pend_in;
      rsp_next.track_power = power_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SYNC;
         zero_count_ff <= 3'd0;
         addr_cnt_ff   <= 3'd0;
         base_ff       <= 4'd0;
         frame_ff      <= 3'd0;
         fbit_ff       <= 4'd0;
         shift_ff      <= 8'd0;
         pend_ff       <= 1'b0;
         writing_ff    <= 1'b0;
         pend_chan_ff  <= '0;
         pend_val_ff   <= 8'd0;
         pend_mask_ff  <= 8'd0;
         power_ff      <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         zero_count_ff <= zero_count_in;
         addr_cnt_ff   <= addr_cnt_in;
         base_ff       <= base_in;
         frame_ff      <= frame_in;
         fbit_ff       <= fbit_in;
         shift_ff      <= shift_in;
         pend_ff       <= pend_in;
         writing_ff    <= writing_in;
         pend_chan_ff  <= pend_chan_in;
         pend_val_ff   <= pend_val_in;
         pend_mask_ff  <= pend_mask_in;
         power_ff      <= power_in;
      end
   end

endmodule

/* design/sxd_chan_mem.sv */
module sxd_chan_mem
   import sxd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  sxd_wr_type        store_wr,
   input  logic              rd_en,
   input  logic              rd_req,
   input  logic [CHAN_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0]          store_ff [CHANNELS];
   logic [CHANNELS-1:0] valid_ff;
   logic [7:0]          rd_data_ff;
   logic                rd_hit_ff, rd_hit_in;

   assign rd_hit_in = rd_req && (rd_addr < CHAN_W'(CHANNELS)) && valid_ff[rd_addr];

   always_ff @(posedge clock) begin
      if (store_wr.en) begin
         store_ff[store_wr.addr] <= store_wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   // an entry never written since reset reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_hit_ff <= 1'b0;
      end else begin
         if (store_wr.en) begin
            valid_ff[store_wr.addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_hit_ff <= rd_hit_in;
         end
      end
   end

   assign rd_data = rd_hit_ff ? rd_data_ff : 8'd0;

endmodule

/* bench/tb_selectrix_bus_decoder.sv */
module tb_selectrix_bus_decoder;
   import sxd_pkg::*;

   localparam logic [1:0] CMD_SPARE = 2'd3;
   localparam int ITEMS = 1000;

   class sx_bus_tracker;
      typedef enum bit [1:0] {HUNT, ADDRESS, FRAMES} bus_phase_type;

      bus_phase_type phase;
      bit [2:0]    zeros;
      bit [2:0]    addr_bit;
      bit [3:0]    base;
      bit [2:0]    frame;
      bit [3:0]    frame_bit;
      bit [7:0]    shifter;
      bit [7:0]    store [CHANNELS];
      bit          wr_pending;
      bit          wr_active;
      bit [6:0]    wr_chan;
      bit [7:0]    wr_value;
      bit [7:0]    wr_mask;
      bit          power;

      sxd_rsp_type expected_rsp [$];
      int          errors;
      int          n_stored;
      int          n_taken;
      int          n_driven;
      int          n_reads;

      function void restart_hunt();
         phase     = HUNT;
         zeros     = 0;
         frame     = 0;
         frame_bit = 0;
      endfunction

      function void drive_bit(int n, inout sxd_rsp_type o);
         if (wr_active && wr_mask[n]) begin
            o.drive_enable = 1'b1;
            o.drive_value  = wr_value[n];
            n_driven++;
         end
      endfunction

      function void frame_edge(bit level, inout sxd_rsp_type o);
         bit [6:0] chan;
         int       n;
         chan = 7'((15 - base) + ((6 - frame) << 4));
         case (frame_bit)
            4'd2, 4'd5, 4'd8: begin
               frame_bit++;
               return;
            end
            4'd0: begin
               if (wr_pending && chan == wr_chan) begin
                  wr_active = 1'b1;
                  drive_bit(0, o);
               end else begin
                  wr_active = 1'b0;
               end
               shifter = {7'd0, level};
               frame_bit++;
               return;
            end
            4'd1: n = 1;
            4'd3: n = 2;
            4'd4: n = 3;
            4'd6: n = 4;
            4'd7: n = 5;
            4'd9: n = 6;
            4'd10: n = 7;
            4'd11: begin
               // a low end bit loses sync and kills any posted write
               if (!level) begin
                  restart_hunt();
                  wr_active  = 1'b0;
                  wr_pending = 1'b0;
                  return;
               end
               if (wr_active) begin
                  wr_active  = 1'b0;
                  wr_pending = 1'b0;
               end
               if (chan < CHANNELS) begin
                  store[chan]      = shifter;
                  o.byte_stored    = 1'b1;
                  o.stored_channel = chan;
                  o.stored_value   = shifter;
                  n_stored++;
               end
               frame++;
               if (frame >= 7) begin
                  restart_hunt();
               end else begin
                  frame_bit = 0;
                  shifter   = 0;
               end
               return;
            end
            default: begin
               frame_bit = 0;
               return;
            end
         endcase
         drive_bit(n, o);
         shifter[n] = shifter[n] | level;
         frame_bit++;
      endfunction

      function void bus_edge(bit level, inout sxd_rsp_type o);
         case (phase)
            ADDRESS: begin
               case (addr_bit)
                  3'd0: power   = level;
                  3'd2: base[3] = level;
                  3'd3: base[2] = level;
                  3'd5: base[1] = level;
                  3'd6: base[0] = level;
                  3'd7: begin
                     phase     = FRAMES;
                     frame     = 0;
                     frame_bit = 0;
                     shifter   = 0;
                  end
                  default: ;
               endcase
               addr_bit++;
            end
            FRAMES: frame_edge(level, o);
            default: begin
               if (!level) begin
                  if (zeros < 4) zeros++;
               end else if (zeros == 3) begin
                  phase    = ADDRESS;
                  base     = 0;
                  addr_bit = 0;
               end else begin
                  zeros = 0;
               end
            end
         endcase
      endfunction

      function sxd_rsp_type decode_step(sxd_req_type r);
         sxd_rsp_type o;
         o = '0;
         case (r.command)
            CMD_EDGE: bus_edge(r.data_bit, o);
            CMD_WRITE: begin
               if (!wr_pending) begin
                  wr_chan            = r.channel;
                  wr_value           = r.write_data;
                  wr_mask            = r.write_mask;
                  wr_pending         = 1'b1;
                  o.request_accepted = 1'b1;
                  n_taken++;
               end
            end
            CMD_READ: begin
               n_reads++;
               if (r.channel < CHANNELS) o.read_data = store[r.channel];
            end
            default: ;
         endcase
         o.write_busy  = wr_pending;
         o.track_power = power;
         return o;
      endfunction

      function void note_request(sxd_req_type r);
         expected_rsp.push_back(decode_step(r));
      endfunction

      function void compare(string field, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
         end
      endfunction

      function void check_response(sxd_rsp_type got);
         sxd_rsp_type want;
         if (expected_rsp.size() == 0) begin
            errors++;
            $display("%0t: response beat %h with nothing expected", $time, got);
            return;
         end
         want = expected_rsp.pop_front();
         compare("drive_enable", 8'(want.drive_enable), 8'(got.drive_enable));
         compare("drive_value", 8'(want.drive_value), 8'(got.drive_value));
         compare("read_data", want.read_data, got.read_data);
         compare("write_busy", 8'(want.write_busy), 8'(got.write_busy));
         compare("request_accepted", 8'(want.request_accepted),
                 8'(got.request_accepted));
         compare("track_power", 8'(want.track_power), 8'(got.track_power));
         compare("byte_stored", 8'(want.byte_stored), 8'(got.byte_stored));
         compare("stored_channel", 8'(want.stored_channel), 8'(got.stored_channel));
         compare("stored_value", want.stored_value, got.stored_value);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   sxd_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   sxd_rsp_type rsp_data;

   sx_bus_tracker tracker = new;

   bit quiet = 1'b0;
   int gap_rate = 0;
   int sent = 0;
   int stall_left = 0;
   int run_left = 0;

   selectrix_bus_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   // response side: check taken beats, stall in random bursts
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.check_response(rsp_data);
      if (quiet) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (run_left > 0) begin
         rsp_stall <= 1'b0;
         run_left--;
      end else if ($urandom_range(0, 3) == 0) begin
         stall_left = $urandom_range(1, 13) - 1;
         rsp_stall <= 1'b1;
      end else begin
         run_left = $urandom_range(1, 40);
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      #4000000;
      $display("tb_selectrix_bus_decoder NOT OK");
      $finish;
   end

   function automatic sxd_req_type make_req(logic [1:0] cmd, bit level, int chan,
                                            int value, int mask);
      sxd_req_type r;
      r.command    = cmd;
      r.data_bit   = level;
      r.channel    = 7'(chan);
      r.write_data = 8'(value);
      r.write_mask = 8'(mask);
      return r;
   endfunction

   function automatic sxd_req_type random_req();
      return make_req(2'($urandom_range(0, 3)), 1'($urandom), $urandom, $urandom, $urandom);
   endfunction

   function automatic int pick_mask();
      case ($urandom_range(0, 3))
         0: return 8'hFF;
         1: return 8'h01 << $urandom_range(0, 7);
         2: return 8'h00;
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   task automatic send_beat(input sxd_req_type r);
      if (!quiet && gap_rate != 0 && $urandom_range(1, 100) <= gap_rate) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_request(r);
      sent++;
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      while (tracker.expected_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic post_write(input int chan);
      send_beat(make_req(CMD_WRITE, 1'($urandom), chan, $urandom, pick_mask()));
   endtask

   // occasionally slip a read or a write between bus edges
   task automatic bus_bit(input bit level);
      sxd_req_type r;
      int          pick;
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
         send_beat(make_req(CMD_READ, 1'($urandom), $urandom_range(0, 127), $urandom,
                            $urandom));
      end else if (pick < 7) begin
         post_write($urandom_range(0, 127));
      end
      r = random_req();
      r.command  = CMD_EDGE;
      r.data_bit = level;
      send_beat(r);
   endtask

   task automatic bus_cycle();
      bit [3:0]  base;
      bit [11:0] bits;
      int        lead;
      int        stop_frame;
      base = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 9) < 6)
         post_write((15 - base) + ((6 - $urandom_range(0, 6)) << 4));
      lead = $urandom_range(3, 5);
      repeat (lead) bus_bit(1'b0);
      if (lead > 3) begin
         bus_bit(1'b1);
         repeat (3) bus_bit(1'b0);
      end
      bus_bit(1'b1);
      bus_bit(1'($urandom));
      bus_bit(1'($urandom));
      bus_bit(base[3]);
      bus_bit(base[2]);
      bus_bit(1'($urandom));
      bus_bit(base[1]);
      bus_bit(base[0]);
      bus_bit(1'($urandom));
      stop_frame = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 7;
      for (int f = 0; f < 7; f++) begin
         bits     = 12'($urandom);
         bits[11] = (f != stop_frame);
         for (int k = 0; k < 12; k++) bus_bit(bits[k]);
         if (f == stop_frame) break;
      end
   endtask

   task automatic noise_burst();
      repeat ($urandom_range(1, 20)) send_beat(random_req());
   endtask

   initial begin
      bit drained;
      drained = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // spare command, reads at both ends, a write that can never match
      send_beat(make_req(CMD_SPARE, 1'b1, 127, 8'hFF, 8'hFF));
      send_beat(make_req(CMD_READ, 1'b0, 0, 0, 0));
      send_beat(make_req(CMD_READ, 1'b1, 127, 8'hFF, 8'hFF));
      send_beat(make_req(CMD_WRITE, 1'b1, 127, 8'hFF, 8'hFF));
      send_beat(make_req(CMD_WRITE, 1'b0, 0, 0, 0));
      // saturated zero run, then a real sync
      repeat (4) send_beat(make_req(CMD_EDGE, 1'b0, 0, 0, 0));
      send_beat(make_req(CMD_EDGE, 1'b1, 0, 0, 0));
      repeat (3) send_beat(make_req(CMD_EDGE, 1'b0, 0, 0, 0));
      send_beat(make_req(CMD_EDGE, 1'b1, 0, 0, 0));
      // address all ones with a low closing bit, then a frame with a low end bit
      repeat (7) send_beat(make_req(CMD_EDGE, 1'b1, 0, 0, 0));
      send_beat(make_req(CMD_EDGE, 1'b0, 0, 0, 0));
      repeat (11) send_beat(make_req(CMD_EDGE, 1'b1, 0, 0, 0));
      send_beat(make_req(CMD_EDGE, 1'b0, 0, 0, 0));

      while (sent < ITEMS) begin
         gap_rate = ($urandom_range(0, 2) == 0) ? 0 : 12;
         if ($urandom_range(0, 6) == 0) noise_burst();
         else bus_cycle();
         if (!drained && sent >= ITEMS / 2) begin
            drain_responses();
            drained = 1'b1;
         end
         if (sent >= ITEMS * 9 / 10) quiet = 1'b1;
      end

      drain_responses();
      repeat (4) @(posedge clock);
      $display("Ran %0d beats: %0d channel bytes stored, %0d reads, %0d writes posted,",
               sent, tracker.n_stored, tracker.n_reads, tracker.n_taken);
      $display("%0d bus bits driven by posted writes, %0d mismatches.",
               tracker.n_driven, tracker.errors);
      if (tracker.errors == 0 && tracker.expected_rsp.size() == 0) begin
         $display("tb_selectrix_bus_decoder OK");
      end else begin
         $display("tb_selectrix_bus_decoder NOT OK");
      end
      $finish;
   end

endmodule
